// ----- rtl/core/tkst_pkg.sv -----
// shared constants and small types for the top-k sorted score table
// no dependencies; used by tkst_cmp, tkst_store and the top level
package tkst_pkg;

   localparam int unsigned DEF_MAX_ENTRIES = 16;
   localparam int unsigned DEF_SCORE_BITS  = 32;

   localparam int unsigned MODE_W      = 2;
   localparam int unsigned IN_SCORE_W  = 32;
   localparam int unsigned NAME_BITS   = 64;
   localparam int unsigned IN_INDEX_W  = 4;
   localparam int unsigned POS_W       = 4;
   localparam int unsigned COUNT_W     = 5;
   localparam int unsigned CAP_W       = 5;
   localparam logic [CAP_W-1:0] CAP_RESET = 5'd10;

   localparam int unsigned REQ_TDATA_W = 104;
   localparam int unsigned RSP_TDATA_W = 16;

   localparam logic [MODE_W-1:0] MODE_ADD    = 2'd0;
   localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_RENAME = 2'd2;

   // compare result of offered key against a stored score
   typedef struct packed {
      logic gt;
      logic eq;
   } cmp_res_type;

   // write strobes into the table memories
   typedef struct packed {
      logic score_en;
      logic name_en;
   } store_wr_type;

endpackage

// ----- rtl/core/tkst_cmp.sv -----
// shared signed score comparator, used for the qualify check and the walk
// depends on tkst_pkg
module tkst_cmp #(
   parameter int unsigned SCORE_BITS = tkst_pkg::DEF_SCORE_BITS
) (
   input  logic [SCORE_BITS-1:0] key,
   input  logic [SCORE_BITS-1:0] stored,
   output tkst_pkg::cmp_res_type res
);

   always_comb begin
      res.gt = $signed(key) > $signed(stored);
      res.eq = key == stored;
   end

endmodule

// ----- rtl/core/tkst_store.sv -----
// score and name tag memories: one write port, one registered read port
// depends on tkst_pkg
module tkst_store #(
   parameter int unsigned MAX_ENTRIES = tkst_pkg::DEF_MAX_ENTRIES,
   parameter int unsigned SCORE_BITS  = tkst_pkg::DEF_SCORE_BITS,
   localparam int unsigned IDX_W      = $clog2(MAX_ENTRIES)
) (
   input  logic                           clock,
   input  tkst_pkg::store_wr_type         wr,
   input  logic [IDX_W-1:0]               wr_addr,
   input  logic [SCORE_BITS-1:0]          wr_score,
   input  logic [tkst_pkg::NAME_BITS-1:0] wr_name,
   input  logic [IDX_W-1:0]               rd_addr,
   output logic [SCORE_BITS-1:0]          rd_score,
   output logic [tkst_pkg::NAME_BITS-1:0] rd_name
);

   logic [SCORE_BITS-1:0]          score_mem [MAX_ENTRIES];
   logic [tkst_pkg::NAME_BITS-1:0] name_mem  [MAX_ENTRIES];

   always_ff @(posedge clock) begin
      if (wr.score_en) begin
         score_mem[wr_addr] <= wr_score;
      end
      if (wr.name_en) begin
         name_mem[wr_addr] <= wr_name;
      end
      rd_score <= score_mem[rd_addr];
      rd_name  <= name_mem[rd_addr];
   end

endmodule

// ----- rtl/core/top_k_sorted_score_table_core.sv -----
// top level of the top-k sorted score table: sequencer, count and result register
// depends on tkst_pkg, tkst_cmp and tkst_store
//
// Keeps up to csr capacity (score, name tag) entries sorted by descending score.
// req channel: one word per command (add, query, rename); rsp channel: one
// result word per command. csr_wr_en/csr_wr_data set the capacity, where 0 acts
// as 1 and values above MAX_ENTRIES as MAX_ENTRIES; a lower capacity drops the
// tail entries at once. Rename, unused mode and query on a table that is not full
// go from idle straight to the done state; query and add on a full table pass the
// qualify state first, where a rejected add ends. Add walks from the tail toward
// the head, one entry per cycle through the single memory read port and the shared
// comparator, then writes the new entry in the insert state. One command is in
// flight at a time; req_tready is high only while the sequencer is idle.
// The result sits in an output register; a stalled rsp side holds it and the
// next command can still be taken, finishing only once the register is free.
// Reset (synchronous, active high) empties the table and sets capacity to 10;
// memory contents are not cleared, no clearing pass is needed.
module top_k_sorted_score_table_core #(
   parameter int unsigned MAX_ENTRIES = tkst_pkg::DEF_MAX_ENTRIES,
   parameter int unsigned SCORE_BITS  = tkst_pkg::DEF_SCORE_BITS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // mode[1:0], score_value[33:2], name_tag[97:34], entry_index[101:98], zero pad
   input  logic [tkst_pkg::REQ_TDATA_W-1:0] req_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // accepted[0], position[4:1], qualifies[5], entry_count[10:6], zero pad
   output logic [tkst_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                             csr_wr_en,
   input  logic [tkst_pkg::CAP_W-1:0]       csr_wr_data
);

   localparam int unsigned IDX_W = $clog2(MAX_ENTRIES);
   localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_QUAL = 3'd1;
   localparam logic [2:0] ST_WALK = 3'd2;
   localparam logic [2:0] ST_INS  = 3'd3;
   localparam logic [2:0] ST_DONE = 3'd4;

   function automatic logic [CNT_W-1:0] eff_cap(input logic [tkst_pkg::CAP_W-1:0] c);
      logic [31:0] c32;
      logic [31:0] r;
      c32 = 32'(c);
      if (c32 == 32'd0) begin
         r = 32'd1;
      end else if (c32 > MAX_ENTRIES) begin
         r = MAX_ENTRIES;
      end else begin
         r = c32;
      end
      return CNT_W'(r);
   endfunction

   // request fields
   logic [tkst_pkg::MODE_W-1:0]     req_mode;
   logic [tkst_pkg::IN_SCORE_W-1:0] req_score;
   logic [tkst_pkg::NAME_BITS-1:0]  req_name;
   logic [tkst_pkg::IN_INDEX_W-1:0] req_index;
   logic [63:0]                     score_ext;
   logic [SCORE_BITS-1:0]           req_key;

   assign req_mode  = req_tdata[1:0];
   assign req_score = req_tdata[33:2];
   assign req_name  = req_tdata[97:34];
   assign req_index = req_tdata[101:98];
   assign score_ext = 64'($signed(req_score));
   assign req_key   = score_ext[SCORE_BITS-1:0];

   logic [2:0]                     state_ff, state_in;
   logic [tkst_pkg::CAP_W-1:0]     cap_ff, cap_in;
   logic [CNT_W-1:0]               held_ff, held_in;
   logic [IDX_W-1:0]               i_ff, i_in;
   logic [tkst_pkg::MODE_W-1:0]    mode_ff, mode_in;
   logic [SCORE_BITS-1:0]          key_ff, key_in;
   logic [tkst_pkg::NAME_BITS-1:0] name_ff, name_in;
   logic                           res_acc_ff, res_acc_in;
   logic [tkst_pkg::POS_W-1:0]     res_pos_ff, res_pos_in;
   logic                           res_qual_ff, res_qual_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [tkst_pkg::RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic [CNT_W-1:0]               cap_eff;
   logic                           full;
   tkst_pkg::store_wr_type         wr;
   logic [IDX_W-1:0]               wr_addr;
   logic [SCORE_BITS-1:0]          wr_score;
   logic [tkst_pkg::NAME_BITS-1:0] wr_name;
   logic [IDX_W-1:0]               rd_addr;
   logic [SCORE_BITS-1:0]          rd_score;
   logic [tkst_pkg::NAME_BITS-1:0] rd_name;
   tkst_pkg::cmp_res_type          cmp;

   assign cap_eff    = eff_cap(cap_ff);
   assign full       = held_ff >= cap_eff;
   assign req_tready = state_ff == ST_IDLE;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   tkst_cmp #(
      .SCORE_BITS(SCORE_BITS)
   ) u_cmp (
      .key   (key_ff),
      .stored(rd_score),
      .res   (cmp)
   );

   tkst_store #(
      .MAX_ENTRIES(MAX_ENTRIES),
      .SCORE_BITS (SCORE_BITS)
   ) u_store (
      .clock   (clock),
      .wr      (wr),
      .wr_addr (wr_addr),
      .wr_score(wr_score),
      .wr_name (wr_name),
      .rd_addr (rd_addr),
      .rd_score(rd_score),
      .rd_name (rd_name)
   );

   always_comb begin
      logic [31:0] idx32;
      logic [31:0] pos32;
      logic [31:0] cnt32;
      logic [CNT_W-1:0] new_cap;
      state_in     = state_ff;
      cap_in       = cap_ff;
      held_in      = held_ff;
      i_in         = i_ff;
      mode_in      = mode_ff;
      key_in       = key_ff;
      name_in      = name_ff;
      res_acc_in   = res_acc_ff;
      res_pos_in   = res_pos_ff;
      res_qual_in  = res_qual_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      wr           = '0;
      wr_addr      = i_ff;
      wr_score     = key_ff;
      wr_name      = name_ff;
      rd_addr      = IDX_W'(held_ff - CNT_W'(1));
      idx32        = 32'(req_index);
      pos32        = 32'(i_ff);
      cnt32        = 32'(held_ff);
      new_cap      = eff_cap(csr_wr_data);

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_wr_en) begin
         cap_in = csr_wr_data;
         if (held_ff > new_cap) begin
            held_in = new_cap;
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               mode_in     = req_mode;
               key_in      = req_key;
               name_in     = req_name;
               res_acc_in  = 1'b0;
               res_pos_in  = '0;
               res_qual_in = 1'b0;
               state_in    = ST_DONE;
               unique case (req_mode)
                  tkst_pkg::MODE_ADD: begin
                     if (full) begin
                        // tail entry must be beaten before anything moves
                        i_in     = IDX_W'(held_ff - CNT_W'(1));
                        state_in = ST_QUAL;
                     end else begin
                        i_in = IDX_W'(held_ff);
                        if (held_ff == '0) begin
                           state_in = ST_INS;
                        end else begin
                           state_in = ST_WALK;
                        end
                     end
                  end
                  tkst_pkg::MODE_QUERY: begin
                     if (full) begin
                        state_in = ST_QUAL;
                     end else begin
                        res_qual_in = 1'b1;
                     end
                  end
                  tkst_pkg::MODE_RENAME: begin
                     if (idx32 < 32'(held_ff)) begin
                        wr.name_en = 1'b1;
                        wr_addr    = idx32[IDX_W-1:0];
                        wr_name    = req_name;
                        res_acc_in = 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_QUAL: begin
            rd_addr = i_ff - IDX_W'(1);
            if (mode_ff == tkst_pkg::MODE_QUERY) begin
               res_qual_in = cmp.gt;
               state_in    = ST_DONE;
            end else if (!cmp.gt) begin
               state_in = ST_DONE;
            end else if (i_ff == '0) begin
               state_in = ST_INS;
            end else begin
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            // read data is entry i-1; move it down while it is not above the key
            rd_addr = i_ff - IDX_W'(2);
            if (cmp.gt || cmp.eq) begin
               wr.score_en = 1'b1;
               wr.name_en  = 1'b1;
               wr_score    = rd_score;
               wr_name     = rd_name;
               i_in        = i_ff - IDX_W'(1);
               if (i_ff == IDX_W'(1)) begin
                  state_in = ST_INS;
               end
            end else begin
               state_in = ST_INS;
            end
         end
         ST_INS: begin
            wr.score_en = 1'b1;
            wr.name_en  = 1'b1;
            if (!full) begin
               held_in = held_ff + CNT_W'(1);
            end
            res_acc_in  = 1'b1;
            res_qual_in = 1'b1;
            res_pos_in  = pos32[tkst_pkg::POS_W-1:0];
            state_in    = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {5'd0, cnt32[tkst_pkg::COUNT_W-1:0], res_qual_ff,
                               res_pos_ff, res_acc_ff};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cap_ff       <= tkst_pkg::CAP_RESET;
         held_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cap_ff       <= cap_in;
         held_ff      <= held_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      i_ff        <= i_in;
      mode_ff     <= mode_in;
      key_ff      <= key_in;
      name_ff     <= name_in;
      res_acc_ff  <= res_acc_in;
      res_pos_ff  <= res_pos_in;
      res_qual_ff <= res_qual_in;
      rsp_data_ff <= rsp_data_in;
   end

   // count never exceeds the effective capacity
   assert property (@(posedge clock) disable iff (reset) held_ff <= cap_eff)
      else $error("entry count above capacity");

   // the walk always has an entry above it to look at
   assert property (@(posedge clock) disable iff (reset) state_ff == ST_WALK |-> i_ff != '0)
      else $error("walk reached the head");

   // a nonzero position only comes with an accepted add
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff[4:1] != '0 |-> rsp_data_ff[0] && rsp_data_ff[5])
      else $error("position reported without insert");

endmodule
